/* hdl/egc_pkg.sv */
// Package for the Elias gamma encoder: sizing constants, item types and the
// command/status structs between the controller and the datapath.
// No dependencies.
package egc_pkg;

    localparam int VALUE_WIDTH  = 32;   // low bits of the value that are encoded
    localparam int LENGTH_BYTES = 8;    // bytes of the length trailer
    localparam int BYTE_BITS    = 8;
    localparam int IN_VALUE_W   = 32;   // width of the value field on the port
    localparam int TOTAL_W      = 64;   // running code length counter

    // Work buffer: one partial byte on top of the widest code or trailer.
    localparam int BODY_W = (LENGTH_BYTES * 8 > 2 * VALUE_WIDTH) ?
                            LENGTH_BYTES * 8 : 2 * VALUE_WIDTH;
    localparam int BUF_W  = BYTE_BITS + BODY_W;
    localparam int FIN_W  = BYTE_BITS + LENGTH_BYTES * 8;
    localparam int FIN_SH = BUF_W - FIN_W;

    localparam int N_W   = $clog2(VALUE_WIDTH);
    localparam int SUM_W = $clog2(2 * VALUE_WIDTH + BYTE_BITS);
    localparam int SH_W  = $clog2(BUF_W);

    localparam int ENC_MAX   = (2 * VALUE_WIDTH + 6) / BYTE_BITS;
    localparam int MAX_BYTES = (LENGTH_BYTES + 1 > ENC_MAX) ? LENGTH_BYTES + 1 : ENC_MAX;
    localparam int CNT_W     = $clog2(MAX_BYTES + 1);

    localparam logic CMD_ENCODE = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

    typedef struct packed {
        logic                  command;
        logic [IN_VALUE_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic [BYTE_BITS-1:0] out_byte;
        logic                 last;
        logic                 error;
    } t_out_item;

    typedef struct packed {
        logic load;     // capture the input transaction
        logic calc;     // find the highest set bit
        logic build;    // assemble the byte buffer and update counters
        logic pop;      // one output byte was taken
        logic commit;   // store the leftover bits or clear the stream
    } t_dp_cmd;

    typedef struct packed {
        logic cnt_zero;
        logic cnt_one;
    } t_dp_status;

endpackage

/* hdl/egc_if.sv */
// Stream interfaces for the Elias gamma encoder input and output channels.
// Depends on egc_pkg for the field widths.
interface egc_in_if;
    logic                           valid;
    logic                           ready;
    logic                           command;
    logic [egc_pkg::IN_VALUE_W-1:0] value;

    modport source (output valid, output command, output value, input ready);
    modport sink   (input valid, input command, input value, output ready);
endinterface

interface egc_out_if;
    logic                          valid;
    logic                          ready;
    logic [egc_pkg::BYTE_BITS-1:0] out_byte;
    logic                          last;
    logic                          error;

    modport source (output valid, output out_byte, output last, output error, input ready);
    modport sink   (input valid, input out_byte, input last, input error, output ready);
endinterface

/* hdl/egc_datapath.sv */
// Datapath of the Elias gamma encoder: leading-one search, byte buffer,
// bit packer state and running length counter. Depends on egc_pkg.
module egc_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  egc_pkg::t_dp_cmd   i_cmd,
    input  egc_pkg::t_in_item  i_item,
    output egc_pkg::t_dp_status o_status,
    output egc_pkg::t_out_item o_item
);
    import egc_pkg::*;

    logic                   r_command;
    logic [VALUE_WIDTH-1:0] r_value;
    logic [N_W-1:0]         r_n;
    logic                   r_err;
    logic [BUF_W-1:0]       r_buf;
    logic [CNT_W-1:0]       r_cnt;
    logic [BYTE_BITS-1:0]   r_partial;   // leftover bits, left-aligned
    logic [2:0]             r_bf;
    logic [TOTAL_W-1:0]     r_total;

    logic [N_W-1:0]         n_n;
    logic [SUM_W-1:0]       w_len;
    logic [SUM_W-1:0]       w_sum;
    logic [SH_W-1:0]        w_shift;
    logic [BUF_W-1:0]       w_code_buf;
    logic [FIN_W-1:0]       w_fin;
    logic [BUF_W-1:0]       w_fin_buf;

    // Highest set bit of the captured value.
    always_comb begin
        n_n = '0;
        for (int i = 0; i < VALUE_WIDTH; i++) begin
            if (r_value[i]) begin
                n_n = N_W'(i);
            end
        end
    end

    always_comb begin
        w_len   = (SUM_W'(r_n) << 1) + SUM_W'(1);
        w_sum   = SUM_W'(r_bf) + w_len;
        // Put the first code bit right below the bits already pending.
        w_shift = SH_W'(BUF_W - 1) - SH_W'(r_bf) - (SH_W'(r_n) << 1);
        w_code_buf = {r_partial, {(BUF_W - BYTE_BITS){1'b0}}}
                   | (BUF_W'(r_value) << w_shift);
        w_fin = {r_partial, r_total[LENGTH_BYTES*8-1:0]};
        if (r_bf == 3'd0) begin
            w_fin = w_fin << BYTE_BITS;
        end
        w_fin_buf = BUF_W'(w_fin) << FIN_SH;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_command <= i_item.command;
            r_value   <= i_item.value[VALUE_WIDTH-1:0];
        end
        if (i_cmd.calc) begin
            r_n   <= n_n;
            r_err <= (r_command == CMD_ENCODE) && (r_value == '0);
        end
        if (i_cmd.build) begin
            if (r_err) begin
                r_buf <= '0;
                r_cnt <= CNT_W'(1);
            end else if (r_command == CMD_FINISH) begin
                r_buf <= w_fin_buf;
                r_cnt <= (r_bf != 3'd0) ? CNT_W'(LENGTH_BYTES + 1) : CNT_W'(LENGTH_BYTES);
            end else begin
                r_buf <= w_code_buf;
                r_cnt <= CNT_W'(w_sum >> 3);
            end
        end else if (i_cmd.pop) begin
            r_buf <= r_buf << BYTE_BITS;
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_partial <= '0;
            r_bf      <= '0;
            r_total   <= '0;
        end else if (i_cmd.build && !r_err && r_command == CMD_ENCODE) begin
            r_bf    <= w_sum[2:0];
            r_total <= r_total + TOTAL_W'(w_len);
        end else if (i_cmd.commit && !r_err) begin
            if (r_command == CMD_FINISH) begin
                r_partial <= '0;
                r_bf      <= '0;
                r_total   <= '0;
            end else begin
                r_partial <= r_buf[BUF_W-1 -: BYTE_BITS];
            end
        end
    end

    assign o_status.cnt_zero = (r_cnt == '0);
    assign o_status.cnt_one  = (r_cnt == CNT_W'(1));
    assign o_item.out_byte   = r_buf[BUF_W-1 -: BYTE_BITS];
    assign o_item.last       = (r_cnt == CNT_W'(1));
    assign o_item.error      = r_err;

endmodule

/* hdl/egc_ctrl.sv */
// Controller of the Elias gamma encoder: sequences capture, search, buffer
// build, byte output and commit. Depends on egc_pkg.
module egc_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    input  egc_pkg::t_dp_status  i_status,
    output egc_pkg::t_dp_cmd     o_cmd
);
    import egc_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CALC   = 3'd1;
    localparam logic [2:0] S_BUILD  = 3'd2;
    localparam logic [2:0] S_EMIT   = 3'd3;
    localparam logic [2:0] S_COMMIT = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state     = r_state;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CALC;
                end
            end
            S_CALC: begin
                o_cmd.calc = 1'b1;
                n_state    = S_BUILD;
            end
            S_BUILD: begin
                o_cmd.build = 1'b1;
                n_state     = S_EMIT;
            end
            S_EMIT: begin
                if (i_status.cnt_zero) begin
                    n_state = S_COMMIT;
                end else begin
                    o_out_valid = 1'b1;
                    if (i_out_ready) begin
                        o_cmd.pop = 1'b1;
                        if (i_status.cnt_one) begin
                            n_state = S_COMMIT;
                        end
                    end
                end
            end
            S_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* hdl/elias_gamma_encoder_unit.sv */
// Elias gamma encoder with MSB-first byte packing and a length trailer.
//
// Input channel i_in carries a command and a 32-bit value. An encode
// command appends the gamma code of the value (n zero bits, then the n+1
// value bits, where n is the highest set bit) to the bit stream; every byte
// that becomes full is sent on o_out. A finish command sends the partial
// byte padded with zeros, if any, then the 64-bit code length in bits as
// eight big-endian bytes, and clears the stream. A zero value gives one
// byte with error set and leaves the stream untouched. The last flag marks
// the final byte caused by one input transaction; an encode that fills no
// byte causes no output transaction.
// Timing: an accepted input transaction is followed by a search state and a
// buffer build state, then one output byte per cycle while the receiver is
// ready (up to nine), then a commit state; an item that sends no byte still
// passes through the output state before the commit.
// The block handles one item at a time, so input ready is low from the
// accepted transaction until the commit cycle has passed. A stall on o_out
// simply holds the current byte. Synchronous reset empties the stream.
// Depends on egc_pkg, egc_if, egc_ctrl and egc_datapath.
module elias_gamma_encoder_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    egc_in_if.sink    i_in,
    egc_out_if.source o_out
);
    import egc_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;
    t_in_item   w_in_item;
    t_out_item  w_out_item;

    assign w_in_item.command = i_in.command;
    assign w_in_item.value   = i_in.value;

    egc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    egc_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_item   (w_in_item),
        .o_status (w_status),
        .o_item   (w_out_item)
    );

    assign o_out.out_byte = w_out_item.out_byte;
    assign o_out.last     = w_out_item.last;
    assign o_out.error    = w_out_item.error;

endmodule

/* tb/elias_gamma_encoder_unit_test.sv */
`timescale 1ns / 100ps
// Self-checking testbench for elias_gamma_encoder_unit: bursty input traffic, a stalling
// receiver and a scoreboard that predicts every packed byte and length trailer.
// Depends on egc_pkg, the egc_in_if/egc_out_if interfaces and the encoder RTL.
module elias_gamma_encoder_unit_test;
    import egc_pkg::*;

    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_RHYTHM} t_rx_mode;

    class egc_stream_tracker;
        t_out_item              expected_bytes[$];
        logic [BYTE_BITS-1:0]   pend_byte;
        logic [2:0]             pend_bits;
        logic [TOTAL_W-1:0]     code_length;
        t_out_item              held;
        bit                     have_held;
        int                     mismatches;

        function new();
            pend_byte   = '0;
            pend_bits   = '0;
            code_length = '0;
            have_held   = 1'b0;
            mismatches  = 0;
        endfunction

        // The newest byte is held back so that the last flag can be set on it.
        function void push_byte(logic [BYTE_BITS-1:0] b, logic err);
            if (have_held) begin
                expected_bytes.insert(expected_bytes.size(), held);
            end
            held.out_byte = b;
            held.last     = 1'b0;
            held.error    = err;
            have_held     = 1'b1;
        endfunction

        function void shift_in_bit(logic b);
            pend_byte = {pend_byte[BYTE_BITS-2:0], b};
            pend_bits = pend_bits + 3'd1;
            // The 3-bit count wraps to zero exactly when the byte is full.
            if (pend_bits == 3'd0) begin
                push_byte(pend_byte, 1'b0);
                pend_byte = '0;
            end
        endfunction

        function void note_input(t_in_item item);
            logic [VALUE_WIDTH-1:0] v;
            logic [BYTE_BITS-1:0]   flushed;
            int                     top;
            int                     i;
            v = item.value[VALUE_WIDTH-1:0];
            if (item.command == CMD_ENCODE) begin
                if (v == '0) begin
                    push_byte('0, 1'b1);
                end else begin
                    top = 0;
                    for (i = 0; i < VALUE_WIDTH; i++) begin
                        if (v[i]) top = i;
                    end
                    code_length = code_length + TOTAL_W'(2 * top + 1);
                    for (i = 0; i < top; i++) shift_in_bit(1'b0);
                    for (i = top; i >= 0; i--) shift_in_bit(v[i]);
                end
            end else begin
                if (pend_bits != 3'd0) begin
                    flushed = pend_byte << (BYTE_BITS - pend_bits);
                    push_byte(flushed, 1'b0);
                end
                for (i = LENGTH_BYTES - 1; i >= 0; i--) begin
                    push_byte(code_length[i*8 +: 8], 1'b0);
                end
                pend_byte   = '0;
                pend_bits   = '0;
                code_length = '0;
            end
            if (have_held) begin
                held.last = 1'b1;
                expected_bytes.insert(expected_bytes.size(), held);
                have_held = 1'b0;
            end
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (expected_bytes.size() == 0) begin
                $display("%0t: unexpected output transaction: byte %h last %b error %b",
                         $time, got.out_byte, got.last, got.error);
                mismatches++;
                return;
            end
            want = expected_bytes.pop_front();
            if (got.out_byte !== want.out_byte) begin
                $display("%0t: out_byte mismatch: expected %h actual %h",
                         $time, want.out_byte, got.out_byte);
                mismatches++;
            end
            if (got.last !== want.last) begin
                $display("%0t: last mismatch: expected %b actual %b",
                         $time, want.last, got.last);
                mismatches++;
            end
            if (got.error !== want.error) begin
                $display("%0t: error mismatch: expected %b actual %b",
                         $time, want.error, got.error);
                mismatches++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    egc_in_if  in_ch();
    egc_out_if out_ch();

    elias_gamma_encoder_unit dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    egc_stream_tracker tracker;
    t_in_item          stimulus[$];
    t_in_item          seen_in;
    t_out_item         seen_out;

    function automatic void queue_item(logic cmd, logic [IN_VALUE_W-1:0] value);
        t_in_item item;
        item.command = cmd;
        item.value   = value;
        stimulus.insert(stimulus.size(), item);
    endfunction

    task automatic send_items();
        int burst;
        int gap;
        int idx;
        idx = 0;
        while (idx < stimulus.size()) begin
            burst = $urandom_range(1, 12);
            while (burst > 0 && idx < stimulus.size()) begin
                in_ch.valid   <= 1'b1;
                in_ch.command <= stimulus[idx].command;
                in_ch.value   <= stimulus[idx].value;
                @(posedge clk);
                while (in_ch.ready !== 1'b1) @(posedge clk);
                idx++;
                burst--;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        in_ch.valid <= 1'b0;
    endtask

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver: switches between stall patterns at random.
    initial begin
        t_rx_mode    mode;
        int          span;
        int unsigned beat;
        beat = 0;
        out_ch.ready <= 1'b0;
        forever begin
            mode = t_rx_mode'($urandom_range(0, 3));
            span = $urandom_range(20, 120);
            repeat (span) begin
                @(posedge clk);
                beat++;
                case (mode)
                    RX_OPEN:   out_ch.ready <= 1'b1;
                    RX_COIN:   out_ch.ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: out_ch.ready <= ($urandom_range(0, 3) == 0);
                    default:   out_ch.ready <= (beat % 5 != 0) && (beat % 7 != 3);
                endcase
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n === 1'b1) begin
            if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) begin
                seen_in.command = in_ch.command;
                seen_in.value   = in_ch.value;
                tracker.note_input(seen_in);
            end
            if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
                seen_out.out_byte = out_ch.out_byte;
                seen_out.last     = out_ch.last;
                seen_out.error    = out_ch.error;
                tracker.check_result(seen_out);
            end
        end
    end

    initial begin
        int                    i;
        int                    pick;
        int                    k;
        int                    wait_cycles;
        logic [IN_VALUE_W-1:0] v;
        logic [IN_VALUE_W-1:0] mask;

        tracker = new();
        rst_n         <= 1'b0;
        in_ch.valid   <= 1'b0;
        in_ch.command <= CMD_ENCODE;
        in_ch.value   <= '0;

        // Directed part: empty finish, zero values, widest codes, byte-aligned finish.
        queue_item(CMD_FINISH, 32'h0000_0000);
        queue_item(CMD_ENCODE, 32'h0000_0000);
        queue_item(CMD_ENCODE, 32'h0000_0001);
        queue_item(CMD_ENCODE, 32'h0000_0000);
        queue_item(CMD_ENCODE, 32'hFFFF_FFFF);
        queue_item(CMD_ENCODE, 32'h8000_0000);
        queue_item(CMD_FINISH, 32'hFFFF_FFFF);
        queue_item(CMD_ENCODE, 32'h0000_000F);
        queue_item(CMD_ENCODE, 32'h0000_0001);
        queue_item(CMD_FINISH, 32'h5A5A_A5A5);
        queue_item(CMD_ENCODE, 32'h0000_0002);
        queue_item(CMD_ENCODE, 32'h0000_0003);
        queue_item(CMD_ENCODE, 32'h0000_007F);
        queue_item(CMD_ENCODE, 32'hAAAA_AAAA);
        queue_item(CMD_ENCODE, 32'h5555_5555);
        queue_item(CMD_ENCODE, 32'h0000_0000);
        queue_item(CMD_FINISH, 32'h0000_0000);
        queue_item(CMD_ENCODE, 32'h0000_0001);
        queue_item(CMD_FINISH, 32'h8000_0001);
        queue_item(CMD_FINISH, 32'h0000_0000);

        for (i = 0; i < 160; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                queue_item(CMD_FINISH, $urandom);
            end else if (pick < 13) begin
                queue_item(CMD_ENCODE, '0);
            end else begin
                // Short codes are favored so that bytes fill at every bit offset.
                k = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 8) : $urandom_range(1, 32);
                mask = (k == IN_VALUE_W) ? '1 : ((IN_VALUE_W'(1) << k) - 1);
                v = $urandom & mask;
                v[k-1] = 1'b1;
                queue_item(CMD_ENCODE, v);
            end
        end
        queue_item(CMD_FINISH, $urandom);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        send_items();

        @(posedge clk);
        wait_cycles = 0;
        while (tracker.expected_bytes.size() > 0 && wait_cycles < 50000) begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (30) @(posedge clk);
        if (tracker.expected_bytes.size() > 0) begin
            $display("%0t: %0d expected output transactions never arrived, next byte %h",
                     $time, tracker.expected_bytes.size(),
                     tracker.expected_bytes[0].out_byte);
            tracker.mismatches++;
        end

        if (tracker.mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("%0t: simulation timed out", $time);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
